// ===== sv/dq_pkg.sv =====
package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int OCC_W         = 5;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_PUSH_FRONT = 2'd0;
   localparam cmd_type CMD_PUSH_BACK  = 2'd1;
   localparam cmd_type CMD_POP_FRONT  = 2'd2;
   localparam cmd_type CMD_POP_BACK   = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [WORD_W-1:0]  data_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  data_out;
      status_type                status;
      logic                      is_empty;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic execute;      // run the command on the request word
      logic load_direct;  // load result register from the request cycle
      logic load_read;    // load result register with popped memory data
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic read_needed;  // request is a pop that will succeed
   } dp_stat_type;

endpackage

// ===== sv/dq_ctrl.sv =====
module dq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dq_pkg::dp_stat_type  dp_stat,
   output dq_pkg::ctl_cmd_type  ctl_cmd
);
   import dq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   // result register is free now or is being emptied this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign ctl_cmd.execute     = accept;
   assign ctl_cmd.load_direct = accept && !dp_stat.read_needed;
   assign ctl_cmd.load_read   = (state_ff == S_READ);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && dp_stat.read_needed) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl_cmd.load_direct || ctl_cmd.load_read) rsp_valid_in = 1'b1;
      else if (rsp_ready)                           rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result slot is empty while a pop waits on its memory read
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("result register busy during pop read");

   // a successful pop always goes to the read state
   a_pop_to_read: assert property (@(posedge clock) disable iff (reset)
      (accept && dp_stat.read_needed) |=> (state_ff == S_READ))
      else $error("pop did not enter read state");

   // read state returns to idle and delivers a word
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("read state did not complete");

endmodule

// ===== sv/dq_datapath.sv =====
module dq_datapath #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dq_pkg::req_type      req_data,
   output dq_pkg::rsp_type      rsp_data,
   input  dq_pkg::ctl_cmd_type  ctl_cmd,
   output dq_pkg::dp_stat_type  dp_stat
);
   import dq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic signed [WORD_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [WORD_W-1:0] rd_data_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   status_type       status_now;
   logic             is_push;
   logic             q_empty;
   logic             q_full;
   logic [PTR_W-1:0] head_up, head_down, tail_up, tail_down;

   // occupancy field view of a count (masked or zero-extended)
   function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+OCC_W-1:0] wide;
      wide   = {{OCC_W{1'b0}}, cnt};
      occ_of = wide[OCC_W-1:0];
   endfunction

   assign head_up   = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign head_down = (head_ff == '0) ? PTR_LAST : head_ff - 1'b1;
   assign tail_up   = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign tail_down = (tail_ff == '0) ? PTR_LAST : tail_ff - 1'b1;

   assign is_push = (req_data.cmd == CMD_PUSH_FRONT) || (req_data.cmd == CMD_PUSH_BACK);
   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CNT_FULL);

   assign dp_stat.read_needed = !is_push && !q_empty;

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_addr    = tail_ff;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      status_now = ST_OK;
      if (ctl_cmd.execute) begin
         unique case (req_data.cmd)
            CMD_PUSH_FRONT: begin
               if (q_full) status_now = ST_FULL;
               else begin
                  head_in  = head_down;
                  wr_en    = 1'b1;
                  wr_addr  = head_down;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               if (q_full) status_now = ST_FULL;
               else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  tail_in  = tail_up;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (q_empty) status_now = ST_EMPTY;
               else begin
                  rd_en    = 1'b1;
                  rd_addr  = head_ff;
                  head_in  = head_up;
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (q_empty) status_now = ST_EMPTY;
               else begin
                  rd_en    = 1'b1;
                  tail_in  = tail_down;
                  rd_addr  = tail_down;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               status_now = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (ctl_cmd.load_direct) begin
         rsp_in.data_out  = '0;
         rsp_in.status    = status_now;
         rsp_in.is_empty  = (count_in == '0);
         rsp_in.occupancy = occ_of(count_in);
      end else if (ctl_cmd.load_read) begin
         rsp_in.data_out  = rd_data_ff;
         rsp_in.status    = ST_OK;
         rsp_in.is_empty  = (count_ff == '0);
         rsp_in.occupancy = occ_of(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_data.data_in;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // held entries never exceed the buffer size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count above depth");

   // a refused push leaves the pointers and count alone
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.execute && is_push && q_full) |=>
         $stable(head_ff) && $stable(tail_ff) && $stable(count_ff))
      else $error("refused push changed state");

   // with the queue empty or full the two pointers meet
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (q_empty || q_full) |-> (head_ff == tail_ff))
      else $error("pointers disagree with count");

endmodule

// ===== sv/double_ended_queue_core.sv =====
// bounded double-ended queue of signed 32-bit words in a circular buffer
//
// input channel req_*: one command word per handshake, req_data.cmd selects
// push front, push back, pop front or pop back; req_data.data_in is the word
// to push and is ignored for pops
// result channel rsp_*: exactly one result word per command, in order: the
// popped word (zero otherwise), a status (ok, empty, full), the empty flag
// and the occupancy after the command
// a push to a full queue returns full and changes nothing; a pop from an
// empty queue returns empty and changes nothing
// push and failed pop results load the result register from the accepted
// command; a successful pop first latches its word in the buffer read port
// throughput: one command per cycle for pushes and failed pops while each
// result is taken; a successful pop holds off new commands while it reads
// a new command is taken while a result waits, as long as that result is
// taken in the same cycle; a stalled receiver holds the result and blocks
// further commands
// reset empties the queue at once; no clearing pass over the buffer
module double_ended_queue_core #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dq_pkg::req_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dq_pkg::rsp_type  rsp_data
);
   import dq_pkg::*;

   // handshake sequencing lives in the controller, buffer and pointers in
   // the datapath
   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .ctl_cmd   (ctl_cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .ctl_cmd  (ctl_cmd),
      .dp_stat  (dp_stat)
   );

endmodule

// ===== verif/tb_double_ended_queue_core.sv =====
module tb_double_ended_queue_core;
   import dq_pkg::*;

   localparam int QDEPTH      = DEPTH_DEFAULT;
   localparam int RANDOM_CMDS = 626;

   // one pending command word with the idle cycles before it and a drain flag
   typedef struct {
      req_type word;
      int      gap;
      bit      drain;
   } stim_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   double_ended_queue_core #(
      .DEPTH(QDEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // shadow copy of the circular buffer
   logic signed [WORD_W-1:0] shadow_store [QDEPTH];
   int shadow_head  = 0;
   int shadow_tail  = 0;
   int shadow_count = 0;

   // tallies for the closing summary
   int n_push_ok  = 0;
   int n_pop_ok   = 0;
   int n_full     = 0;
   int n_empty    = 0;
   int peak_count = 0;

   logic [WORD_W-1:0] corner_words [4] =
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

   stim_type cmd_backlog [$];
   rsp_type  due_results [$];

   int fail_count = 0;
   int rsp_count  = 0;
   bit idle_seen  = 1'b0;

   // handshake flags, set at the rising edge and cleared at the falling edge
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;

   // sender state
   bit on_bus   = 1'b0;
   int gap_left = 0;

   // receiver state
   int stall_left = 0;
   int hold_left  = 0;
   bit rsp_calm   = 1'b0;
   bit rsp_go     = 1'b0;

   // apply one command to the shadow deque and return the result word it owes
   function automatic rsp_type deque_apply(req_type w);
      rsp_type r;
      r        = '0;
      r.status = ST_OK;
      if (w.cmd == CMD_PUSH_FRONT || w.cmd == CMD_PUSH_BACK) begin
         if (shadow_count >= QDEPTH) begin
            r.status = ST_FULL;
            n_full++;
         end else begin
            if (w.cmd == CMD_PUSH_FRONT) begin
               shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
               shadow_store[shadow_head] = w.data_in;
            end else begin
               shadow_store[shadow_tail] = w.data_in;
               shadow_tail = (shadow_tail + 1) % QDEPTH;
            end
            shadow_count++;
            n_push_ok++;
         end
      end else if (shadow_count == 0) begin
         r.status = ST_EMPTY;
         n_empty++;
      end else begin
         if (w.cmd == CMD_POP_FRONT) begin
            r.data_out  = shadow_store[shadow_head];
            shadow_head = (shadow_head + 1) % QDEPTH;
         end else begin
            shadow_tail = (shadow_tail + QDEPTH - 1) % QDEPTH;
            r.data_out  = shadow_store[shadow_tail];
         end
         shadow_count--;
         n_pop_ok++;
      end
      r.is_empty  = (shadow_count == 0);
      r.occupancy = shadow_count[OCC_W-1:0];
      if (shadow_count > peak_count) peak_count = shadow_count;
      return r;
   endfunction

   function automatic void note_field(string what, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
         fail_count++;
      end
   endfunction

   task automatic queue_cmd(cmd_type c, logic [WORD_W-1:0] d, int gap, bit drain);
      stim_type s;
      s.word.cmd     = c;
      s.word.data_in = d;
      s.gap          = gap;
      s.drain        = drain;
      cmd_backlog.push_back(s);
   endtask

   // monitor: check result words first, then predict for the accepted command
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            rsp_count++;
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result word, expected none got %0h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               note_field("data_out", want.data_out, rsp_data.data_out);
               note_field("status", WORD_W'(want.status), WORD_W'(rsp_data.status));
               note_field("is_empty", WORD_W'(want.is_empty),
                          WORD_W'(rsp_data.is_empty));
               note_field("occupancy", WORD_W'(want.occupancy),
                          WORD_W'(rsp_data.occupancy));
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            due_results.push_back(deque_apply(req_data));
         end
         idle_seen = (cmd_backlog.size() == 0) && !req_valid && (due_results.size() == 0);
      end
   end

   // sender: holds each word until taken, then waits its gap before the next
   always @(negedge clock) begin
      stim_type next;
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            on_bus    = 1'b0;
            if (cmd_backlog.size() != 0) gap_left = cmd_backlog[0].gap;
         end
         if (!on_bus) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_backlog.size() != 0 &&
                         (!cmd_backlog[0].drain || due_results.size() == 0)) begin
               next = cmd_backlog.pop_front();
               req_data <= next.word;
               on_bus = 1'b1;
            end
         end
      end
      req_valid <= on_bus;
   end

   // receiver: random stall per result word, calm stretches, two long hold-offs
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            stall_left = rsp_calm ? 0 : $urandom_range(0, 19);
            // long hold lets the sender back up against a blocked input
            if (rsp_count == 60 || rsp_count == 400) hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_go = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_go = 1'b0;
         end else begin
            rsp_go = 1'b1;
         end
      end
      rsp_ready <= rsp_go;
   end

   initial begin
      int                seg_left;
      int                push_pct;
      bit                calm;
      cmd_type           c;
      logic [WORD_W-1:0] word;

      // pops on an empty queue from both ends
      queue_cmd(CMD_POP_FRONT, 32'h1234_5678, $urandom_range(0, 19), 1'b0);
      queue_cmd(CMD_POP_BACK, 32'hFFFF_FFFF, $urandom_range(0, 19), 1'b0);
      // extreme words in and out at opposite ends, wrapping the head below zero
      queue_cmd(CMD_PUSH_BACK, 32'h7FFF_FFFF, $urandom_range(0, 19), 1'b0);
      queue_cmd(CMD_PUSH_FRONT, 32'h8000_0000, $urandom_range(0, 19), 1'b0);
      queue_cmd(CMD_POP_BACK, 32'h0, $urandom_range(0, 19), 1'b0);
      queue_cmd(CMD_POP_FRONT, 32'h0, $urandom_range(0, 19), 1'b0);
      // fill to the brim from both ends, then push into a full queue
      for (int i = 0; i < QDEPTH; i++) begin
         queue_cmd((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, corner_words[i % 4],
                   $urandom_range(0, 19), 1'b0);
      end
      queue_cmd(CMD_PUSH_FRONT, 32'hDEAD_BEEF, $urandom_range(0, 19), 1'b0);
      queue_cmd(CMD_PUSH_BACK, 32'h0BAD_F00D, $urandom_range(0, 19), 1'b0);

      // random walk in segments that lean toward filling, draining or neither
      seg_left = 0;
      push_pct = 50;
      calm     = 1'b0;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(12, 40);
            case ($urandom_range(0, 2))
               0: begin
                  push_pct = 80;
               end
               1: begin
                  push_pct = 20;
               end
               default: begin
                  push_pct = 50;
               end
            endcase
            calm = ($urandom_range(0, 3) == 0);
         end
         seg_left--;
         if ($urandom_range(0, 99) < push_pct)
            c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         else
            c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
         word = ($urandom_range(0, 7) == 0) ? corner_words[$urandom_range(0, 3)]
                                            : $urandom;
         // every so often the sender waits for all results before going on
         queue_cmd(c, word, calm ? 0 : $urandom_range(0, 19), (n % 160) == 0);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (!idle_seen);
      // keep running so a stray result word would still be caught
      repeat (8) @(negedge clock);

      $display("ran %0d commands: %0d pushes stored, %0d pops returned a word",
               n_push_ok + n_pop_ok + n_full + n_empty, n_push_ok, n_pop_ok);
      $display("refused %0d pushes as full and %0d pops as empty, peak occupancy %0d",
               n_full, n_empty, peak_count);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
